// ===== hw/rtl/decimal_number_text_parser_assert.svh =====
// assertion macros for the decimal number text parser
`ifndef DECIMAL_NUMBER_TEXT_PARSER_ASSERT_SVH
`define DECIMAL_NUMBER_TEXT_PARSER_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define DNTP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DNTP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dntp_pkg.sv =====
// shared types and constants for the decimal number text parser
`default_nettype none
package dntp_pkg;

    localparam int MANT_DIGITS_DEF = 19;
    localparam int EXP_MAX_DEF     = 9999;

    localparam int CHAR_W = 8;
    localparam int MANT_W = 64;
    localparam int EXP_W  = 15;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic signed [EXP_W-1:0] SCALE_MAX = {1'b0, {(EXP_W-1){1'b1}}};
    localparam logic signed [EXP_W-1:0] SCALE_MIN = {1'b1, {(EXP_W-1){1'b0}}};

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LC_E  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UC_E  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_DIGIT,
        K_SPACE,
        K_MINUS,
        K_PLUS,
        K_DOT,
        K_EXP,
        K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

// ===== hw/rtl/dntp_front.sv =====
// front end: input handshake and character classification
`default_nettype none
module dntp_front (
    input  wire logic                        i_valid,
    input  wire logic [dntp_pkg::CHAR_W-1:0] i_character,
    input  wire logic                        i_last,
    input  wire dntp_pkg::t_qstat            i_qstat,
    output logic                             o_stall,
    output logic                             o_push,
    output dntp_pkg::t_beat                  o_beat
);

    logic [dntp_pkg::CHAR_W-1:0] w_offset;

    assign o_stall  = i_qstat.full;
    assign o_push   = i_valid && !i_qstat.full;
    assign w_offset = i_character - dntp_pkg::CH_ZERO;

    always_comb begin
        o_beat.last  = i_last;
        o_beat.digit = 4'd0;
        priority if (i_character >= dntp_pkg::CH_ZERO && i_character <= dntp_pkg::CH_NINE) begin
            o_beat.kind  = dntp_pkg::K_DIGIT;
            o_beat.digit = w_offset[3:0];
        end else if ((i_character >= dntp_pkg::CH_TAB && i_character <= dntp_pkg::CH_CR) ||
                     i_character == dntp_pkg::CH_SPACE) begin
            o_beat.kind = dntp_pkg::K_SPACE;
        end else if (i_character == dntp_pkg::CH_MINUS) begin
            o_beat.kind = dntp_pkg::K_MINUS;
        end else if (i_character == dntp_pkg::CH_PLUS) begin
            o_beat.kind = dntp_pkg::K_PLUS;
        end else if (i_character == dntp_pkg::CH_DOT) begin
            o_beat.kind = dntp_pkg::K_DOT;
        end else if (i_character == dntp_pkg::CH_LC_E || i_character == dntp_pkg::CH_UC_E) begin
            o_beat.kind = dntp_pkg::K_EXP;
        end else begin
            o_beat.kind = dntp_pkg::K_OTHER;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dntp_queue.sv =====
// short queue of classified beats between front and back
`default_nettype none
module dntp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dntp_pkg::t_beat i_beat,
    input  wire logic            i_pop,
    output dntp_pkg::t_beat      o_head,
    output dntp_pkg::t_qstat     o_qstat
);

    dntp_pkg::t_beat              r_mem [dntp_pkg::Q_DEPTH];
    logic [dntp_pkg::Q_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [dntp_pkg::Q_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [dntp_pkg::Q_AW:0]      r_count, n_count;

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == (dntp_pkg::Q_AW+1)'(dntp_pkg::Q_DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == dntp_pkg::Q_AW'(dntp_pkg::Q_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == dntp_pkg::Q_AW'(dntp_pkg::Q_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dntp_back.sv =====
// back end: grammar state machine, digit accumulation and result register
`default_nettype none
module dntp_back #(
    parameter int MANT_DIGITS = dntp_pkg::MANT_DIGITS_DEF,
    parameter int EXP_MAX     = dntp_pkg::EXP_MAX_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dntp_pkg::t_beat            i_beat,
    input  wire logic                       i_beat_valid,
    input  wire logic                       i_stall,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic                            o_negative,
    output logic [dntp_pkg::MANT_W-1:0]     o_mantissa,
    output logic signed [dntp_pkg::EXP_W-1:0] o_decimal_exponent,
    output logic                            o_inexact
);

    localparam int KW  = $clog2(MANT_DIGITS + 1);
    localparam int EW  = $clog2(EXP_MAX + 1);
    localparam int EXW = EW + 4;
    localparam int TW  = dntp_pkg::EXP_W + 1;

    typedef enum logic [5:0] {
        PH_WS         = 6'b000001,
        PH_INT        = 6'b000010,
        PH_FRAC       = 6'b000100,
        PH_EXP_START  = 6'b001000,
        PH_EXP_DIGITS = 6'b010000,
        PH_DONE       = 6'b100000
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic                                r_minus, n_minus;
    logic [dntp_pkg::MANT_W-1:0]         r_acc, n_acc;
    logic [KW-1:0]                       r_kept, n_kept;
    logic signed [dntp_pkg::EXP_W-1:0]   r_scale, n_scale;
    logic                                r_exp_minus, n_exp_minus;
    logic [EW-1:0]                       r_exp_val, n_exp_val;
    logic                                r_lost, n_lost;

    logic                                r_out_valid;
    logic                                r_out_negative;
    logic [dntp_pkg::MANT_W-1:0]         r_out_mantissa;
    logic signed [dntp_pkg::EXP_W-1:0]   r_out_exponent;
    logic                                r_out_inexact;

    logic                                w_take_digit;
    logic                                w_fraction;
    logic                                w_take_exp;
    logic                                w_scale_up;
    logic                                w_scale_down;
    logic [dntp_pkg::MANT_W-1:0]         w_acc_next;
    logic [EXW-1:0]                      w_exp_next;
    logic signed [TW-1:0]                w_scale_ext;
    logic signed [TW-1:0]                w_exp_ext;
    logic signed [TW-1:0]                w_total;
    logic signed [dntp_pkg::EXP_W-1:0]   w_total_sat;
    logic                                w_inexact;
    logic                                w_finish;

    // a last beat needs the result register free or being emptied this cycle
    assign o_pop    = i_beat_valid && (!i_beat.last || !r_out_valid || !i_stall);
    assign w_finish = o_pop && i_beat.last;

    always_comb begin
        n_phase      = r_phase;
        n_minus      = r_minus;
        n_exp_minus  = r_exp_minus;
        w_take_digit = 1'b0;
        w_fraction   = 1'b0;
        w_take_exp   = 1'b0;
        unique case (r_phase)
            PH_WS: begin
                unique case (i_beat.kind)
                    dntp_pkg::K_SPACE: begin
                    end
                    dntp_pkg::K_MINUS: begin
                        n_minus = 1'b1;
                        n_phase = PH_INT;
                    end
                    dntp_pkg::K_PLUS: begin
                        n_phase = PH_INT;
                    end
                    dntp_pkg::K_DIGIT: begin
                        w_take_digit = 1'b1;
                        n_phase      = PH_INT;
                    end
                    dntp_pkg::K_DOT: begin
                        n_phase = PH_FRAC;
                    end
                    dntp_pkg::K_EXP: begin
                        n_phase = PH_EXP_START;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
            PH_INT: begin
                unique case (i_beat.kind)
                    dntp_pkg::K_DIGIT: w_take_digit = 1'b1;
                    dntp_pkg::K_DOT:   n_phase = PH_FRAC;
                    dntp_pkg::K_EXP:   n_phase = PH_EXP_START;
                    default:           n_phase = PH_DONE;
                endcase
            end
            PH_FRAC: begin
                unique case (i_beat.kind)
                    dntp_pkg::K_DIGIT: begin
                        w_take_digit = 1'b1;
                        w_fraction   = 1'b1;
                    end
                    dntp_pkg::K_EXP: n_phase = PH_EXP_START;
                    default:         n_phase = PH_DONE;
                endcase
            end
            PH_EXP_START: begin
                unique case (i_beat.kind)
                    dntp_pkg::K_MINUS: begin
                        n_exp_minus = 1'b1;
                        n_phase     = PH_EXP_DIGITS;
                    end
                    dntp_pkg::K_PLUS: n_phase = PH_EXP_DIGITS;
                    dntp_pkg::K_DIGIT: begin
                        w_take_exp = 1'b1;
                        n_phase    = PH_EXP_DIGITS;
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
            PH_EXP_DIGITS: begin
                if (i_beat.kind == dntp_pkg::K_DIGIT) begin
                    w_take_exp = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // times ten as two shifts and an add
    assign w_acc_next = (r_acc << 3) + (r_acc << 1) + dntp_pkg::MANT_W'(i_beat.digit);
    assign w_exp_next = (EXW'(r_exp_val) << 3) + (EXW'(r_exp_val) << 1)
                      + EXW'(i_beat.digit);

    always_comb begin
        n_acc        = r_acc;
        n_kept       = r_kept;
        n_scale      = r_scale;
        n_exp_val    = r_exp_val;
        n_lost       = r_lost;
        w_scale_up   = 1'b0;
        w_scale_down = 1'b0;
        if (w_take_digit) begin
            if (r_kept < KW'(MANT_DIGITS)) begin
                n_acc = w_acc_next;
                // leading zeros keep the accumulator at zero and use no slot
                if (w_acc_next != '0) begin
                    n_kept = r_kept + 1'b1;
                end
                w_scale_down = w_fraction;
            end else begin
                if (i_beat.digit != 4'd0) begin
                    n_lost = 1'b1;
                end
                w_scale_up = !w_fraction;
            end
        end
        if (w_scale_up) begin
            if (r_scale == dntp_pkg::SCALE_MAX) begin
                n_lost = 1'b1;
            end else begin
                n_scale = r_scale + dntp_pkg::EXP_W'(1);
            end
        end
        if (w_scale_down) begin
            if (r_scale == dntp_pkg::SCALE_MIN) begin
                n_lost = 1'b1;
            end else begin
                n_scale = r_scale - dntp_pkg::EXP_W'(1);
            end
        end
        if (w_take_exp) begin
            if (w_exp_next > EXW'(EXP_MAX)) begin
                n_exp_val = EW'(EXP_MAX);
                n_lost    = 1'b1;
            end else begin
                n_exp_val = w_exp_next[EW-1:0];
            end
        end
    end

    assign w_scale_ext = TW'(n_scale);
    assign w_exp_ext   = $signed(TW'(n_exp_val));
    assign w_total     = n_exp_minus ? (w_scale_ext - w_exp_ext) : (w_scale_ext + w_exp_ext);

    always_comb begin
        w_inexact   = n_lost;
        w_total_sat = w_total[dntp_pkg::EXP_W-1:0];
        if (w_total > TW'(dntp_pkg::SCALE_MAX)) begin
            w_total_sat = dntp_pkg::SCALE_MAX;
            w_inexact   = 1'b1;
        end else if (w_total < TW'(dntp_pkg::SCALE_MIN)) begin
            w_total_sat = dntp_pkg::SCALE_MIN;
            w_inexact   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WS;
            r_minus     <= 1'b0;
            r_acc       <= '0;
            r_kept      <= '0;
            r_scale     <= '0;
            r_exp_minus <= 1'b0;
            r_exp_val   <= '0;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_finish) begin
                r_phase     <= PH_WS;
                r_minus     <= 1'b0;
                r_acc       <= '0;
                r_kept      <= '0;
                r_scale     <= '0;
                r_exp_minus <= 1'b0;
                r_exp_val   <= '0;
                r_lost      <= 1'b0;
            end else if (o_pop) begin
                r_phase     <= n_phase;
                r_minus     <= n_minus;
                r_acc       <= n_acc;
                r_kept      <= n_kept;
                r_scale     <= n_scale;
                r_exp_minus <= n_exp_minus;
                r_exp_val   <= n_exp_val;
                r_lost      <= n_lost;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_negative <= n_minus;
            r_out_mantissa <= n_acc;
            r_out_exponent <= w_total_sat;
            r_out_inexact  <= w_inexact;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_negative         = r_out_negative;
    assign o_mantissa         = r_out_mantissa;
    assign o_decimal_exponent = r_out_exponent;
    assign o_inexact          = r_out_inexact;

endmodule
`default_nettype wire

// ===== hw/rtl/decimal_number_text_parser.sv =====
// top level of the decimal number text parser
//
//  channel   dir  handshake              payload
//  input     in   i_valid / o_stall      i_character[7:0], i_last
//  result    out  o_valid / i_stall      o_negative, o_mantissa[63:0],
//                                        o_decimal_exponent[14:0], o_inexact
//
// one character per cycle sustained, except while a held result blocks the last character of a number
// a beat is written into the two-entry queue, and the back end takes it from the queue head into its state
// the result is valid from the cycle after its last character is processed
// reset is synchronous and active low; no clearing pass is needed
// a held result stops only the last character of the next number in the back end; the input stalls once the queue fills
`default_nettype none
`include "decimal_number_text_parser_assert.svh"
module decimal_number_text_parser #(
    parameter int MANT_DIGITS = dntp_pkg::MANT_DIGITS_DEF,
    parameter int EXP_MAX     = dntp_pkg::EXP_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [dntp_pkg::CHAR_W-1:0]    i_character,
    input  wire logic                           i_last,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_negative,
    output logic [dntp_pkg::MANT_W-1:0]         o_mantissa,
    output logic signed [dntp_pkg::EXP_W-1:0]   o_decimal_exponent,
    output logic                                o_inexact
);

    dntp_pkg::t_qstat w_qstat;
    dntp_pkg::t_beat  w_in_beat;
    dntp_pkg::t_beat  w_head;
    logic             w_push;
    logic             w_pop;

    dntp_front u_front (
        .i_valid     (i_valid),
        .i_character (i_character),
        .i_last      (i_last),
        .i_qstat     (w_qstat),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_beat      (w_in_beat)
    );

    dntp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_beat  (w_in_beat),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    dntp_back #(
        .MANT_DIGITS (MANT_DIGITS),
        .EXP_MAX     (EXP_MAX)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_beat             (w_head),
        .i_beat_valid       (!w_qstat.empty),
        .i_stall            (i_stall),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .o_negative         (o_negative),
        .o_mantissa         (o_mantissa),
        .o_decimal_exponent (o_decimal_exponent),
        .o_inexact          (o_inexact)
    );

    `DNTP_ASSERT_IMPL(a_pop_nonempty, w_pop, !w_qstat.empty, "pop from empty queue")
    `DNTP_ASSERT_NEXT(a_last_gives_result, w_pop && w_head.last, o_valid, "no result after last beat")
    `DNTP_ASSERT_IMPL(a_result_from_last, $rose(o_valid), $past(w_pop && w_head.last), "result without last beat")

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the decimal number text parser: directed, saturation, random-text and back-pressure tests
module tb_top;
    import dntp_pkg::*;

    localparam int SIG_DIGITS      = MANT_DIGITS_DEF;
    localparam int EXP_CAP         = EXP_MAX_DEF;
    localparam int SCALE_HI        = SCALE_MAX;
    localparam int SCALE_LO        = SCALE_MIN;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_CHARS    = 250;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_WHOLE,
        PH_FRAC,
        PH_EXP_SIGN,
        PH_EXP_DIG,
        PH_STOP
    } parse_phase_t;

    typedef enum int {SNK_FREE, SNK_RANDOM, SNK_PATTERN} sink_mode_t;

    typedef struct {
        logic                    negative;
        logic [MANT_W-1:0]       mantissa;
        logic signed [EXP_W-1:0] dexp;
        logic                    inexact;
    } number_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic [CHAR_W-1:0]       i_character = '0;
    logic                    i_last = 1'b0;
    logic                    i_stall = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic                    o_negative;
    logic [MANT_W-1:0]       o_mantissa;
    logic signed [EXP_W-1:0] o_decimal_exponent;
    logic                    o_inexact;

    decimal_number_text_parser dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_character        (i_character),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_negative         (o_negative),
        .o_mantissa         (o_mantissa),
        .o_decimal_exponent (o_decimal_exponent),
        .o_inexact          (o_inexact)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // number being parsed, as the block should see it
    parse_phase_t      num_phase;
    logic              num_minus;
    logic [MANT_W-1:0] num_digits;
    int                num_kept;
    int                num_scale;
    logic              num_exp_minus;
    int                num_exp_value;
    logic              num_lost;

    number_result_t    expected_numbers[$];
    logic [CHAR_W-1:0] text_buf[$];

    int         errors = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;
    bit         beat_seen = 1'b0;
    bit         src_gaps = 1'b0;
    int         burst_left = 0;
    sink_mode_t snk_mode = SNK_FREE;
    int         hold_len = 0;
    logic [15:0] stall_pattern = 16'b0111_0000_1100_0010;

    function automatic void clear_number();
        num_phase     = PH_LEAD;
        num_minus     = 1'b0;
        num_digits    = '0;
        num_kept      = 0;
        num_scale     = 0;
        num_exp_minus = 1'b0;
        num_exp_value = 0;
        num_lost      = 1'b0;
    endfunction

    function automatic bit is_digit(logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_space(logic [CHAR_W-1:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic bit is_exp_mark(logic [CHAR_W-1:0] c);
        return c == CH_LC_E || c == CH_UC_E;
    endfunction

    function automatic void shift_scale(int delta);
        int s;
        s = num_scale + delta;
        if (s > SCALE_HI) begin
            s = SCALE_HI;
            num_lost = 1'b1;
        end
        if (s < SCALE_LO) begin
            s = SCALE_LO;
            num_lost = 1'b1;
        end
        num_scale = s;
    endfunction

    // leading zeros keep the accumulator at zero and use no digit slot
    function automatic void absorb_digit(int d, bit in_frac);
        if (num_kept < SIG_DIGITS) begin
            num_digits = num_digits * 10 + d;
            if (num_digits != 0) num_kept++;
            if (in_frac) shift_scale(-1);
        end else begin
            if (d != 0) num_lost = 1'b1;
            if (!in_frac) shift_scale(1);
        end
    endfunction

    function automatic void absorb_exp_digit(int d);
        int v;
        v = num_exp_value * 10 + d;
        if (v > EXP_CAP) begin
            v = EXP_CAP;
            num_lost = 1'b1;
        end
        num_exp_value = v;
    endfunction

    function automatic void parse_char(logic [CHAR_W-1:0] c, logic closes);
        number_result_t r;
        int             total;
        case (num_phase)
            PH_LEAD: begin
                if (!is_space(c)) begin
                    if (c == CH_MINUS) begin
                        num_minus = 1'b1;
                        num_phase = PH_WHOLE;
                    end else if (c == CH_PLUS) begin
                        num_phase = PH_WHOLE;
                    end else if (is_digit(c)) begin
                        absorb_digit(c - CH_ZERO, 1'b0);
                        num_phase = PH_WHOLE;
                    end else if (c == CH_DOT) begin
                        num_phase = PH_FRAC;
                    end else if (is_exp_mark(c)) begin
                        num_phase = PH_EXP_SIGN;
                    end else begin
                        num_phase = PH_STOP;
                    end
                end
            end
            PH_WHOLE: begin
                if (is_digit(c)) absorb_digit(c - CH_ZERO, 1'b0);
                else if (c == CH_DOT) num_phase = PH_FRAC;
                else if (is_exp_mark(c)) num_phase = PH_EXP_SIGN;
                else num_phase = PH_STOP;
            end
            PH_FRAC: begin
                if (is_digit(c)) absorb_digit(c - CH_ZERO, 1'b1);
                else if (is_exp_mark(c)) num_phase = PH_EXP_SIGN;
                else num_phase = PH_STOP;
            end
            PH_EXP_SIGN: begin
                if (c == CH_MINUS) begin
                    num_exp_minus = 1'b1;
                    num_phase = PH_EXP_DIG;
                end else if (c == CH_PLUS) begin
                    num_phase = PH_EXP_DIG;
                end else if (is_digit(c)) begin
                    absorb_exp_digit(c - CH_ZERO);
                    num_phase = PH_EXP_DIG;
                end else begin
                    num_phase = PH_STOP;
                end
            end
            PH_EXP_DIG: begin
                if (is_digit(c)) absorb_exp_digit(c - CH_ZERO);
                else num_phase = PH_STOP;
            end
            default: ;
        endcase
        if (closes) begin
            total = num_exp_minus ? num_scale - num_exp_value : num_scale + num_exp_value;
            r.inexact = num_lost;
            // final sum saturates even for a zero mantissa
            if (total > SCALE_HI) begin
                total = SCALE_HI;
                r.inexact = 1'b1;
            end
            if (total < SCALE_LO) begin
                total = SCALE_LO;
                r.inexact = 1'b1;
            end
            r.negative = num_minus;
            r.mantissa = num_digits;
            r.dexp     = total[EXP_W-1:0];
            expected_numbers.push_back(r);
            clear_number();
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch in %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
    endtask

    // one character beat; valid stays up into the next call unless a gap follows
    task automatic send_char(logic [CHAR_W-1:0] c, logic closes);
        bit taken;
        taken = 1'b0;
        i_valid     <= 1'b1;
        i_character <= c;
        i_last      <= closes;
        while (!taken) begin
            @(negedge i_clk);
            if (!o_stall) begin
                taken = 1'b1;
                beat_seen = 1'b1;
                parse_char(c, closes);
            end
            @(posedge i_clk);
        end
        if (src_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic send_text(string s, bit closes);
        for (int k = 0; k < s.len(); k++) send_char(s[k], closes && k == s.len() - 1);
    endtask

    task automatic send_fill(logic [CHAR_W-1:0] c, int n);
        repeat (n) send_char(c, 1'b0);
    endtask

    task automatic send_buffer();
        foreach (text_buf[k]) send_char(text_buf[k], k == text_buf.size() - 1);
    endtask

    task automatic source_rest();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_digit();
        if ($urandom_range(0, 9) < 4) return CH_ZERO;
        return CH_ZERO + $urandom_range(0, 9);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(17, 26);
        return $urandom_range(0, 6);
    endfunction

    // mostly well-formed numbers; some get a byte corrupted, some are pure noise
    function automatic void compose_number();
        text_buf.delete();
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4)) text_buf.push_back($urandom_range(0, 255));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1)) text_buf.push_back(CH_SPACE);
            else text_buf.push_back(CH_TAB + $urandom_range(0, 4));
        end
        case ($urandom_range(0, 3))
            0: text_buf.push_back(CH_MINUS);
            1: text_buf.push_back(CH_PLUS);
            default: ;
        endcase
        repeat (pick_len()) text_buf.push_back(pick_digit());
        if ($urandom_range(0, 1)) begin
            text_buf.push_back(CH_DOT);
            repeat (pick_len()) text_buf.push_back(pick_digit());
        end
        if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
            case ($urandom_range(0, 2))
                0: text_buf.push_back(CH_MINUS);
                1: text_buf.push_back(CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 6)) text_buf.push_back(pick_digit());
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back($urandom_range(0, 255));
        if (text_buf.size() > 0 && $urandom_range(0, 5) == 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = $urandom_range(0, 255);
        if (text_buf.size() == 0) text_buf.push_back(pick_digit());
    endfunction

    // receiver stall: long hold-off first, otherwise the current pattern
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len--;
        end else begin
            case (snk_mode)
                SNK_FREE: i_stall <= 1'b0;
                SNK_RANDOM: i_stall <= ($urandom_range(0, 99) < 35);
                default: begin
                    i_stall <= stall_pattern[15];
                    stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
                end
            endcase
        end
    end

    // result beats are checked at the falling edge, before the edge that takes them
    always @(negedge i_clk) begin
        number_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            beat_seen = 1'b1;
            results_seen++;
            if (expected_numbers.size() == 0) begin
                report_mismatch("unexpected result, mantissa", o_mantissa, '0);
            end else begin
                want = expected_numbers.pop_front();
                if (o_negative !== want.negative)
                    report_mismatch("negative", o_negative, want.negative);
                if (o_mantissa !== want.mantissa)
                    report_mismatch("mantissa", o_mantissa, want.mantissa);
                if (o_decimal_exponent !== want.dexp)
                    report_mismatch("decimal_exponent", o_decimal_exponent, want.dexp);
                if (o_inexact !== want.inexact)
                    report_mismatch("inexact", o_inexact, want.inexact);
            end
        end
    end

    always @(posedge i_clk) begin
        if (beat_seen) idle_cycles = 0;
        else idle_cycles++;
        beat_seen = 1'b0;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        src_gaps = 1'b1;
        snk_mode = SNK_RANDOM;
        send_text("0", 1'b1);
        send_text("-0", 1'b1);
        send_text("+9999999999999999999", 1'b1);
        send_text("000120", 1'b1);
        send_text("0.000450", 1'b1);
        send_text("-12.5e3", 1'b1);
        send_text("1.5E-7", 1'b1);
        // too many digits: nonzero ones lost set inexact, zeros do not
        send_text("12345678901234567890123", 1'b1);
        send_text("10000000000000000000000", 1'b1);
        send_text("0.12345678901234567890123", 1'b1);
        send_text("0.10000000000000000000000", 1'b1);
        send_text("1e99999", 1'b1);
        // no digits, bare marks
        send_text("-e5", 1'b1);
        send_text(".e-3", 1'b1);
        send_text("1e", 1'b1);
        send_text("1e+", 1'b1);
        send_text("-", 1'b1);
        send_text(".", 1'b1);
        // a sign, space, other character or second exponent mark after the number stops parsing
        send_text("12+5", 1'b1);
        send_text("1.5 7", 1'b1);
        send_text("3.25x9e9", 1'b1);
        send_text("5e3e2", 1'b1);
        for (int c = CH_TAB; c <= CH_CR; c++) send_char(c, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_text("42", 1'b1);
        send_char(CH_TAB - 8'd1, 1'b0);
        send_char(CH_CR + 8'd1, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        source_rest();
    endtask

    // long digit runs past the mantissa limit, some with an exponent value beyond its cap
    task automatic test_saturation();
        src_gaps = 1'b0;
        snk_mode = SNK_PATTERN;
        send_text("1", 1'b0);
        send_fill(CH_ZERO, 25);
        send_text("e999999", 1'b1);
        send_text(".", 1'b0);
        send_fill(CH_ZERO, 25);
        send_text("1e-999999", 1'b1);
        send_text("-9", 1'b0);
        send_fill(CH_ZERO + 8'd5, 25);
        send_text("e-12", 1'b1);
        send_text("0.", 1'b0);
        send_fill(CH_ZERO, 25);
        send_text("1", 1'b1);
        source_rest();
    endtask

    task automatic test_random_text();
        int sent;
        int numbers;
        sent = 0;
        numbers = 0;
        while (sent < RANDOM_CHARS) begin
            if (numbers % 8 == 0) begin
                snk_mode = sink_mode_t'((numbers / 8) % 3);
                src_gaps = ((numbers / 8) % 4) < 2;
            end
            compose_number();
            send_buffer();
            sent += text_buf.size();
            numbers++;
        end
        source_rest();
    endtask

    // receiver holds off while short numbers keep coming, so the input backs up
    task automatic test_pressure();
        src_gaps = 1'b0;
        snk_mode = SNK_FREE;
        hold_len = HOLD_OFF_CYCLES;
        repeat (60) begin
            text_buf.delete();
            if ($urandom_range(0, 1)) text_buf.push_back(CH_MINUS);
            repeat ($urandom_range(1, 3)) text_buf.push_back(pick_digit());
            send_buffer();
        end
        source_rest();
    endtask

    initial begin
        clear_number();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_saturation();
        test_random_text();
        test_pressure();
        while (expected_numbers.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_numbers.size() != 0)
            report_mismatch("results never delivered", expected_numbers.size(), 0);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dntp_pkg.sv
hw/rtl/dntp_front.sv
hw/rtl/dntp_queue.sv
hw/rtl/dntp_back.sv
hw/rtl/decimal_number_text_parser.sv
dv/tb_top.sv
